### rtl/czpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package czpm_pkg;

  localparam int MAX_ZEROS_DEF  = 10;
  localparam int MAX_ORDER_DEF  = 15;
  localparam int COORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int INVALID_COORD  = 1000;

  localparam logic [1:0] REG_AMPLITUDE  = 2'd0;
  localparam logic [1:0] REG_ZERO_COUNT = 2'd1;
  localparam logic [1:0] REG_POLE_ORDER = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic signed [31:0] pixel_x;
    logic signed [31:0] pixel_y;
    logic               pixel_valid;
    logic               parity;
    logic [3:0]         zero_slot;
    logic signed [31:0] zero_re;
    logic signed [31:0] zero_im;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic               out_valid;
    logic               out_parity;
    logic               overflow;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_MULSUM,
    ST_MULRND,
    ST_POLE,
    ST_DPROD,
    ST_DSUM,
    ST_DIVR,
    ST_DIVI,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### rtl/complex_zero_polynomial_pole_map_core.sv
// A pixel request runs the zero product (one complex multiply per zero) and then one complex
// division per pole order; a pole at the origin skips the divisions, an invalid pixel goes
// straight to its result and a load gives no result.
// busy drops in the out_strobe cycle, so the next request can be accepted right then; the block
// shares one 32x32 multiplier and uses a one-bit-per-cycle divider. The receiver cannot stall.
// Synchronous reset clears the zero tables and sets amplitude 1.0, zero_count 1, pole_order 0.
`timescale 1ns / 1ps
`default_nettype none
module complex_zero_polynomial_pole_map_core #(
  parameter int MAX_ZEROS = czpm_pkg::MAX_ZEROS_DEF,
  parameter int MAX_ORDER = czpm_pkg::MAX_ORDER_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  czpm_pkg::in_item_t  in_item,
  output logic                out_strobe,
  output czpm_pkg::out_item_t out_item,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [31:0]         cfg_data
);

  localparam int CB = czpm_pkg::COORD_BITS_DEF;
  localparam int FB = czpm_pkg::FRAC_BITS_DEF;
  localparam int PW = 2 * CB + 2;          // product sums
  localparam int NW = PW + FB;             // shifted numerator width
  localparam int DC = NW;                  // divider steps
  localparam int ZW = (MAX_ZEROS > 1) ? $clog2(MAX_ZEROS) : 1;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam longint INVALID_COORD_L = longint'(czpm_pkg::INVALID_COORD);
  localparam logic signed [CB-1:0] INV_C = CB'(-(INVALID_COORD_L << FB));

  logic signed [CB-1:0] amp_r;
  logic [3:0]           zcnt_r, pord_r;
  logic signed [CB-1:0] zre_r [MAX_ZEROS];
  logic signed [CB-1:0] zim_r [MAX_ZEROS];

  czpm_pkg::state_t state_r, state_nxt;
  logic signed [CB-1:0] zx_r, zy_r, wr_r, wi_r, dr_r, di_r;
  logic [ZW:0]          k_r;
  logic [4:0]           j_r;
  logic [2:0]           ph_r;
  logic                 par_r, ovf_r;
  logic signed [2*CB-1:0] prod_r;
  logic signed [PW-1:0] acc_a_r, acc_b_r;
  logic [PW-1:0]        den_r;
  logic [NW-1:0]        num_r, rem_r, q_r;
  logic                 neg_r;
  logic [CW-1:0]        cnt_r;
  logic                 out_strobe_r;
  czpm_pkg::out_item_t  out_r;

  logic [ZW:0] nz;
  logic [4:0]  nord;
  assign nz   = ({1'b0, zcnt_r} > 5'(MAX_ZEROS)) ? (ZW+1)'(MAX_ZEROS) : (ZW+1)'(zcnt_r);
  assign nord = ({1'b0, pord_r} > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : {1'b0, pord_r};

  function automatic logic signed [CB-1:0] sat_v(input logic signed [PW+1:0] v);
    if (v > PW'(CMAX)) return CMAX;
    if (v < $signed({{(PW+2-CB){1'b1}}, CMIN})) return CMIN;
    return v[CB-1:0];
  endfunction
  function automatic logic is_sat(input logic signed [PW+1:0] v);
    return (v > PW'(CMAX)) || (v < $signed({{(PW+2-CB){1'b1}}, CMIN}));
  endfunction

  // Shared multiplier operands.
  logic signed [CB-1:0] ma, mb;
  always_comb begin
    ma = wr_r;
    mb = dr_r;
    if (state_r == czpm_pkg::ST_MUL) begin
      unique case (ph_r)
        3'd0: begin ma = wr_r; mb = dr_r; end
        3'd1: begin ma = wi_r; mb = di_r; end
        3'd2: begin ma = wr_r; mb = di_r; end
        default: begin ma = wi_r; mb = dr_r; end
      endcase
    end else begin
      unique case (ph_r)
        3'd0: begin ma = zx_r; mb = zx_r; end
        3'd1: begin ma = zy_r; mb = zy_r; end
        3'd2: begin ma = wr_r; mb = zx_r; end
        3'd3: begin ma = wi_r; mb = zy_r; end
        3'd4: begin ma = wi_r; mb = zx_r; end
        default: begin ma = wr_r; mb = zy_r; end
      endcase
    end
  end

  // Rounded multiply results and differences.
  logic signed [PW+1:0] rnd_a, rnd_b, d_re, d_im;
  logic [ZW-1:0]        kidx;
  assign kidx  = k_r[ZW-1:0] - 1'b1;
  assign rnd_a = (PW+2)'((acc_a_r + PW'(1 << (FB-1))) >>> FB);
  assign rnd_b = (PW+2)'((acc_b_r + PW'(1 << (FB-1))) >>> FB);
  assign d_re  = (PW+2)'(zx_r) - (PW+2)'(zre_r[kidx]);
  assign d_im  = (PW+2)'(zy_r) - (PW+2)'(zim_r[kidx]);

  // Divider step and final rounding.
  logic [NW:0]   trial;
  logic [NW-1:0] rem_sh;
  logic [NW:0]   qr;
  logic [PW+1:0] qc;
  logic signed [PW+1:0] qs;
  assign rem_sh = {rem_r[NW-2:0], num_r[NW-1]};
  assign trial  = {1'b0, rem_sh} - {{(NW+1-PW){1'b0}}, den_r};
  assign qr     = {1'b0, q_r} +
                  {{NW{1'b0}}, ({rem_r, 1'b0} >= {{(NW+1-PW){1'b0}}, den_r})};
  // A quotient magnitude of 2^(CB+1) or more is clamped to 2^CB before the sign goes on.
  assign qc     = (qr[NW:CB+1] != '0) ? ((PW+2)'(1) << CB) : (PW+2)'(qr[CB:0]);
  assign qs     = neg_r ? -$signed(qc) : $signed(qc);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      czpm_pkg::ST_IDLE:
        if (start && in_item.req_type == czpm_pkg::REQ_PIXEL) begin
          state_nxt = in_item.pixel_valid ? czpm_pkg::ST_DIFF : czpm_pkg::ST_DONE;
        end
      czpm_pkg::ST_DIFF:   state_nxt = (k_r == '0) ? czpm_pkg::ST_POLE : czpm_pkg::ST_MUL;
      czpm_pkg::ST_MUL:    state_nxt = czpm_pkg::ST_MULSUM;
      czpm_pkg::ST_MULSUM: state_nxt = (ph_r == 3'd3) ? czpm_pkg::ST_MULRND : czpm_pkg::ST_MUL;
      czpm_pkg::ST_MULRND: state_nxt = czpm_pkg::ST_DIFF;
      czpm_pkg::ST_POLE: begin
        if (j_r == '0) state_nxt = czpm_pkg::ST_DONE;
        else if (zx_r == '0 && zy_r == '0) state_nxt = czpm_pkg::ST_DONE;
        else state_nxt = czpm_pkg::ST_DPROD;
      end
      czpm_pkg::ST_DPROD:  state_nxt = czpm_pkg::ST_DSUM;
      czpm_pkg::ST_DSUM:   state_nxt = (ph_r == 3'd5) ? czpm_pkg::ST_DIVR : czpm_pkg::ST_DPROD;
      czpm_pkg::ST_DIVR:   state_nxt = (cnt_r == CW'(DC)) ? czpm_pkg::ST_DIVI : state_r;
      czpm_pkg::ST_DIVI:   state_nxt = (cnt_r == CW'(DC)) ? czpm_pkg::ST_POLE : state_r;
      czpm_pkg::ST_DONE:   state_nxt = czpm_pkg::ST_IDLE;
      default:             state_nxt = czpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = (state_r != czpm_pkg::ST_IDLE);
    cfg_ready  = (state_r == czpm_pkg::ST_IDLE);
    out_strobe = out_strobe_r;
    out_item   = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= czpm_pkg::ST_IDLE;
      amp_r        <= CB'(1 << FB);
      zcnt_r       <= 4'd1;
      pord_r       <= 4'd0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < MAX_ZEROS; i++) begin
        zre_r[i] <= '0;
        zim_r[i] <= '0;
      end
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          czpm_pkg::REG_AMPLITUDE:  amp_r  <= cfg_data;
          czpm_pkg::REG_ZERO_COUNT: zcnt_r <= cfg_data[3:0];
          czpm_pkg::REG_POLE_ORDER: pord_r <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (state_r == czpm_pkg::ST_IDLE && start && in_item.req_type == czpm_pkg::REQ_LOAD
          && {1'b0, in_item.zero_slot} < 5'(MAX_ZEROS)) begin
        zre_r[in_item.zero_slot[ZW-1:0]] <= in_item.zero_re;
        zim_r[in_item.zero_slot[ZW-1:0]] <= in_item.zero_im;
      end
      if (state_r == czpm_pkg::ST_DONE) out_strobe_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      czpm_pkg::ST_IDLE: begin
        zx_r  <= in_item.pixel_x;
        zy_r  <= in_item.pixel_y;
        wr_r  <= amp_r;
        wi_r  <= '0;
        k_r   <= nz;
        j_r   <= nord;
        ph_r  <= '0;
        ovf_r <= 1'b0;
        par_r <= in_item.parity;
        out_r <= '{out_x: INV_C, out_y: INV_C, out_valid: 1'b0, out_parity: 1'b0,
                   overflow: 1'b0};
      end
      czpm_pkg::ST_DIFF: begin
        if (k_r != '0) begin
          k_r  <= k_r - 1'b1;
          dr_r <= sat_v(d_re);
          di_r <= sat_v(d_im);
          if (is_sat(d_re) || is_sat(d_im)) ovf_r <= 1'b1;
          ph_r <= '0;
        end
      end
      czpm_pkg::ST_MUL, czpm_pkg::ST_DPROD: prod_r <= ma * mb;
      czpm_pkg::ST_MULSUM: begin
        unique case (ph_r)
          3'd0: acc_a_r <= PW'(prod_r);
          3'd1: acc_a_r <= acc_a_r - PW'(prod_r);
          3'd2: acc_b_r <= PW'(prod_r);
          default: acc_b_r <= acc_b_r + PW'(prod_r);
        endcase
        ph_r <= ph_r + 1'b1;
      end
      czpm_pkg::ST_MULRND: begin
        wr_r <= sat_v(rnd_a);
        wi_r <= sat_v(rnd_b);
        if (is_sat(rnd_a) || is_sat(rnd_b)) ovf_r <= 1'b1;
      end
      czpm_pkg::ST_POLE: begin
        ph_r <= '0;
        if (j_r != '0 && zx_r == '0 && zy_r == '0) begin
          wr_r  <= CMAX;
          wi_r  <= CMAX;
          ovf_r <= 1'b1;
        end
        if (j_r != '0) j_r <= j_r - 1'b1;
      end
      czpm_pkg::ST_DSUM: begin
        // Denominator first, then the real numerator in acc_a and the imaginary one in acc_b.
        unique case (ph_r)
          3'd0: den_r <= PW'(prod_r);
          3'd1: den_r <= den_r + PW'(prod_r);
          3'd2: acc_a_r <= PW'(prod_r);
          3'd3: acc_a_r <= acc_a_r + PW'(prod_r);
          3'd4: acc_b_r <= PW'(prod_r);
          default: begin
            acc_b_r <= acc_b_r - PW'(prod_r);
            neg_r   <= acc_a_r < 0;
            num_r   <= ((acc_a_r < 0) ? NW'(-acc_a_r) : NW'(acc_a_r)) << FB;
            rem_r   <= '0;
            q_r     <= '0;
            cnt_r   <= '0;
          end
        endcase
        ph_r <= ph_r + 1'b1;
      end
      czpm_pkg::ST_DIVR, czpm_pkg::ST_DIVI: begin
        if (cnt_r != CW'(DC)) begin
          num_r <= num_r << 1;
          cnt_r <= cnt_r + 1'b1;
          if (!trial[NW]) begin
            rem_r <= trial[NW-1:0];
            q_r   <= {q_r[NW-2:0], 1'b1};
          end else begin
            rem_r <= rem_sh;
            q_r   <= {q_r[NW-2:0], 1'b0};
          end
        end else begin
          if (is_sat(qs)) ovf_r <= 1'b1;
          if (state_r == czpm_pkg::ST_DIVR) begin
            dr_r  <= sat_v(qs);
            neg_r <= acc_b_r < 0;
            num_r <= ((acc_b_r < 0) ? NW'(-acc_b_r) : NW'(acc_b_r)) << FB;
            rem_r <= '0;
            q_r   <= '0;
            cnt_r <= '0;
          end else begin
            wr_r <= dr_r;
            wi_r <= sat_v(qs);
          end
        end
      end
      default: ;
    endcase
    if (state_nxt == czpm_pkg::ST_DONE && state_r != czpm_pkg::ST_IDLE) begin
      out_r <= '{out_x: (state_r == czpm_pkg::ST_POLE && j_r != '0) ? CMAX : wr_r,
                 out_y: (state_r == czpm_pkg::ST_POLE && j_r != '0) ? CMAX : wi_r,
                 out_valid: 1'b1, out_parity: par_r,
                 overflow: ovf_r || (state_r == czpm_pkg::ST_POLE && j_r != '0)};
    end
  end

endmodule
`default_nettype wire

### dv/complex_zero_polynomial_pole_map_core_tb.sv
`timescale 1ns / 1ps
module complex_zero_polynomial_pole_map_core_tb;

  localparam int NZ = czpm_pkg::MAX_ZEROS_DEF;
  localparam int NO = czpm_pkg::MAX_ORDER_DEF;
  localparam int FRAC = czpm_pkg::FRAC_BITS_DEF;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam logic signed [63:0] C_MAX = 64'sd2147483647;
  localparam logic signed [63:0] C_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  czpm_pkg::in_item_t in_item = '0;
  logic out_strobe;
  czpm_pkg::out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = czpm_pkg::REG_AMPLITUDE;
  logic [31:0] cfg_data = '0;

  complex_zero_polynomial_pole_map_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow state of the block.
  logic signed [63:0] root_re [NZ];
  logic signed [63:0] root_im [NZ];
  logic signed [63:0] gain;
  logic [3:0] root_cnt;
  logic [3:0] pole_pow;
  bit clip_seen;

  czpm_pkg::in_item_t request_q[$];
  czpm_pkg::out_item_t mapped_q[$];
  int idle_pct = 0;
  int errors = 0;
  int quiet = 0;
  bit took = 1'b0;

  function automatic logic signed [63:0] clip(logic signed [127:0] v);
    if (v > C_MAX) begin
      clip_seen = 1'b1;
      return C_MAX;
    end
    if (v < C_MIN) begin
      clip_seen = 1'b1;
      return C_MIN;
    end
    return v[63:0];
  endfunction

  // Rounded quotient v * 2^16 / den, ties away from zero; den is positive.
  function automatic logic signed [127:0] div_round(logic signed [127:0] v,
                                                    logic [127:0] den);
    logic [127:0] mag, q, r;
    mag = (v < 0) ? -v : v;
    mag = mag << FRAC;
    q = mag / den;
    r = mag % den;
    if ((r << 1) >= den) q = q + 1;
    return (v < 0) ? -q : q;
  endfunction

  function automatic czpm_pkg::out_item_t map_pixel(czpm_pkg::in_item_t it);
    czpm_pkg::out_item_t res;
    logic signed [63:0] zx, zy, wr, wi, dr, di;
    logic signed [127:0] pr, pi, den;
    int n, ord;
    res = '0;
    if (!it.pixel_valid) begin
      res.out_x = 32'(-(czpm_pkg::INVALID_COORD <<< FRAC));
      res.out_y = 32'(-(czpm_pkg::INVALID_COORD <<< FRAC));
      return res;
    end
    clip_seen = 1'b0;
    zx = it.pixel_x;
    zy = it.pixel_y;
    wr = gain;
    wi = 0;
    n = (root_cnt > NZ) ? NZ : root_cnt;
    for (int k = n - 1; k >= 0; k--) begin
      dr = clip(zx - root_re[k]);
      di = clip(zy - root_im[k]);
      pr = wr * dr - wi * di;
      pi = wr * di + wi * dr;
      wr = clip((pr + 128'sd32768) >>> FRAC);
      wi = clip((pi + 128'sd32768) >>> FRAC);
    end
    ord = (pole_pow > NO) ? NO : pole_pow;
    if (ord > 0 && zx == 0 && zy == 0) begin
      clip_seen = 1'b1;
      wr = C_MAX;
      wi = C_MAX;
    end else begin
      for (int j = 0; j < ord; j++) begin
        den = zx * zx + zy * zy;
        pr = wr * zx + wi * zy;
        pi = wi * zx - wr * zy;
        wr = clip(div_round(pr, den));
        wi = clip(div_round(pi, den));
      end
    end
    res.out_x = wr[31:0];
    res.out_y = wi[31:0];
    res.out_valid = 1'b1;
    res.out_parity = it.parity;
    res.overflow = clip_seen;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
  endtask

  // Request driver: a new request goes out only after the previous one was taken.
  always @(negedge clk) begin
    if (rst_n && (!start || took)) begin
      if (request_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        start <= 1'b1;
        in_item <= request_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: updates the shadow state and checks every result.
  always @(posedge clk) begin
    took = 1'b0;
    if (!rst_n) begin
      for (int k = 0; k < NZ; k++) begin
        root_re[k] = 0;
        root_im[k] = 0;
      end
      gain = 64'sd65536;
      root_cnt = 4'd1;
      pole_pow = 4'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        quiet = 0;
        case (cfg_index)
          czpm_pkg::REG_AMPLITUDE:  gain = $signed(cfg_data);
          czpm_pkg::REG_ZERO_COUNT: root_cnt = cfg_data[3:0];
          czpm_pkg::REG_POLE_ORDER: pole_pow = cfg_data[3:0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        took = 1'b1;
        quiet = 0;
        if (in_item.req_type == czpm_pkg::REQ_LOAD) begin
          if (in_item.zero_slot < NZ) begin
            root_re[in_item.zero_slot] = in_item.zero_re;
            root_im[in_item.zero_slot] = in_item.zero_im;
          end
        end else begin
          mapped_q.push_back(map_pixel(in_item));
        end
      end
      if (out_strobe) begin
        quiet = 0;
        if (mapped_q.size() == 0) begin
          report_mismatch("unexpected result", out_item.out_x, '0);
        end else begin
          czpm_pkg::out_item_t want;
          want = mapped_q.pop_front();
          if (out_item.out_x !== want.out_x)
            report_mismatch("out_x", out_item.out_x, want.out_x);
          if (out_item.out_y !== want.out_y)
            report_mismatch("out_y", out_item.out_y, want.out_y);
          if (out_item.out_valid !== want.out_valid)
            report_mismatch("out_valid", out_item.out_valid, want.out_valid);
          if (out_item.out_parity !== want.out_parity)
            report_mismatch("out_parity", out_item.out_parity, want.out_parity);
          if (out_item.overflow !== want.overflow)
            report_mismatch("overflow", out_item.overflow, want.overflow);
        end
      end
      quiet++;
      if (quiet >= WATCH_LIMIT) begin
        $display("watchdog expired, %0d results outstanding", mapped_q.size());
        $display("** complex_zero_polynomial_pole_map_core: FAILED **");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3, 4: return $urandom;
      default: return $urandom_range(0, 32'h80000) - 32'h40000;
    endcase
  endfunction

  function automatic czpm_pkg::in_item_t pick_request();
    czpm_pkg::in_item_t it;
    int kind;
    it = '0;
    kind = $urandom_range(0, 99);
    it.pixel_x = pick_coord();
    it.pixel_y = pick_coord();
    it.parity = 1'($urandom_range(0, 1));
    it.zero_slot = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                               : 4'($urandom_range(0, 9));
    it.zero_re = pick_coord();
    it.zero_im = pick_coord();
    it.req_type = (kind < 15) ? czpm_pkg::REQ_LOAD : czpm_pkg::REQ_PIXEL;
    it.pixel_valid = (kind >= 25);
    return it;
  endfunction

  function automatic czpm_pkg::in_item_t make_load(int slot, logic [31:0] re,
                                                   logic [31:0] im);
    czpm_pkg::in_item_t it;
    it = '0;
    it.req_type = czpm_pkg::REQ_LOAD;
    it.zero_slot = 4'(slot);
    it.zero_re = re;
    it.zero_im = im;
    return it;
  endfunction

  function automatic czpm_pkg::in_item_t make_pixel(logic [31:0] x, logic [31:0] y,
                                                    logic ok, logic par);
    czpm_pkg::in_item_t it;
    it = '0;
    it.req_type = czpm_pkg::REQ_PIXEL;
    it.pixel_x = x;
    it.pixel_y = y;
    it.pixel_valid = ok;
    it.parity = par;
    return it;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Loads give no result; the wait ends once nothing is queued or outstanding and the block is idle.
  task automatic wait_drained();
    while (request_q.size() > 0 || start || mapped_q.size() > 0 || busy)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  int phase_len [11] = '{0, 165, 165, 165, 165, 165, 165, 30, 165, 165, 275};
  logic [31:0] phase_gain [11] = '{32'h10000, 32'h10000, 32'h18000, 32'hffff0000,
                                   32'h7fffffff, 32'h80000000, 32'h0, 32'h8000,
                                   32'h10000, 32'h0, 32'h0};
  logic [3:0] phase_roots [11] = '{1, 3, 10, 0, 15, 1, 4, 2, 12, 5, 1};
  logic [3:0] phase_pole [11] = '{0, 0, 1, 2, 0, 1, 3, 15, 4, 0, 2};
  int idle_mix [3] = '{0, 86, 21};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: table fill, slots past the end, extremes, an invalid pixel.
    for (int k = 0; k < NZ; k++)
      request_q.push_back(make_load(k, (k - 4) <<< 16, (3 - k) <<< 15));
    request_q.push_back(make_load(10, 32'h7fffffff, 32'h80000000));
    request_q.push_back(make_load(15, 32'h80000000, 32'h7fffffff));
    request_q.push_back(make_pixel(32'h0, 32'h0, 1'b1, 1'b1));
    request_q.push_back(make_pixel(32'h7fffffff, 32'h7fffffff, 1'b1, 1'b0));
    request_q.push_back(make_pixel(32'h80000000, 32'h80000000, 1'b1, 1'b1));
    request_q.push_back(make_pixel(32'h7fffffff, 32'h80000000, 1'b1, 1'b1));
    request_q.push_back(make_pixel(32'h12345, 32'hfffe0000, 1'b0, 1'b1));
    request_q.push_back(make_pixel(32'h10000, 32'h0, 1'b1, 1'b0));
    request_q.push_back(make_load(0, 32'h0, 32'h0));
    request_q.push_back(make_pixel(32'h0, 32'h0, 1'b1, 1'b0));
    wait_drained();
    write_reg(REG_NONE, 32'hffffffff);

    // Pole at the origin and division with extreme operands.
    write_reg(czpm_pkg::REG_POLE_ORDER, 32'd2);
    request_q.push_back(make_pixel(32'h0, 32'h0, 1'b1, 1'b1));
    request_q.push_back(make_pixel(32'h1, 32'h0, 1'b1, 1'b1));
    request_q.push_back(make_pixel(32'h80000000, 32'h7fffffff, 1'b1, 1'b0));
    wait_drained();

    for (int p = 1; p < 11; p++) begin
      write_reg(czpm_pkg::REG_AMPLITUDE, (p == 6 || p == 9) ? $urandom : phase_gain[p]);
      write_reg(czpm_pkg::REG_ZERO_COUNT, {28'd0, phase_roots[p]});
      write_reg(czpm_pkg::REG_POLE_ORDER, {28'd0, phase_pole[p]});
      idle_pct = idle_mix[p % 3];
      for (int i = 0; i < phase_len[p]; i++) request_q.push_back(pick_request());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("** complex_zero_polynomial_pole_map_core: PASSED **");
    end else begin
      $display("** complex_zero_polynomial_pole_map_core: FAILED **");
    end
    $finish;
  end

endmodule
